// File: rtl/core/ctc_pkg.sv
// Shared types, constants and helper functions for the CTC tone generator.
// Used by every module of the block; depends on nothing else.
package ctc_pkg;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [23:0] CPU_HZ   = 24'd16000000;

  // Multiplying a 32-bit value by this and shifting right by 38 divides it by 1000 exactly.
  localparam logic [31:0] MS_RECIP       = 32'h10624DD3;
  localparam int          MS_RECIP_SHIFT = 38;

  // Serial divider geometry.
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PS_STOP    = 3'b000,
    PS_DIV1    = 3'b001,
    PS_DIV8    = 3'b010,
    PS_DIV64   = 3'b011,
    PS_DIV256  = 3'b100,
    PS_DIV1024 = 3'b101
  } prescale_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_START,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  pin_mask;
    logic [23:0] frequency_hz;
    logic [15:0] duration_ms;
  } ctc_in_t;

  typedef struct packed {
    logic [7:0] port_bits;
    logic       running;
    logic       compare_event;
    logic       bad_start;
  } ctc_out_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  pin_mask;
    logic [23:0] frequency_hz;
    logic [15:0] duration_ms;
  } ctc_cmd_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Right shift that divides by the selected prescaler.
  function automatic logic [3:0] prescale_shift(prescale_t sel);
    logic [3:0] sh;
    unique case (sel)
      PS_DIV8:    sh = 4'd3;
      PS_DIV64:   sh = 4'd6;
      PS_DIV256:  sh = 4'd8;
      PS_DIV1024: sh = 4'd10;
      default:    sh = 4'd0;
    endcase
    return sh;
  endfunction

  // Last prescaler count before a prescaled clock; unknown codes act as divide by one.
  function automatic logic [9:0] prescale_top(prescale_t sel);
    logic [9:0] top;
    unique case (sel)
      PS_DIV8:    top = 10'd7;
      PS_DIV64:   top = 10'd63;
      PS_DIV256:  top = 10'd255;
      PS_DIV1024: top = 10'd1023;
      default:    top = 10'd0;
    endcase
    return top;
  endfunction

endpackage

// File: rtl/core/ctc_div.sv
// Restoring divider, one quotient bit per cycle, used by the start sequence.
// Depends on ctc_pkg for the request and response structs.
module ctc_div
  import ctc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     dsr_r, dsr_nxt;
  logic [DIV_W:0]       trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, quo_r[DIV_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '1;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// File: rtl/core/ctc_front.sv
// Input stage: accepts items, sorts them into tick, start and rejected start.
// Depends on ctc_pkg for the item and command types.
module ctc_front
  import ctc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctc_in_t  in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output ctc_cmd_t cmd_data
);

  logic     hold_valid_r;
  ctc_cmd_t hold_cmd_r;
  ctc_cmd_t cls;

  always_comb begin
    cls.pin_mask     = in_data.pin_mask;
    cls.frequency_hz = in_data.frequency_hz;
    cls.duration_ms  = in_data.duration_ms;
    if (in_data.operation == OP_START) begin
      cls.kind = (in_data.frequency_hz == '0) ? CMD_BAD : CMD_START;
    end else begin
      cls.kind = CMD_TICK;
    end
  end

  assign in_ready  = !hold_valid_r || cmd_ready;
  assign cmd_valid = hold_valid_r;
  assign cmd_data  = hold_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid_r <= 1'b1;
    end else if (cmd_ready) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_cmd_r <= cls;
    end
  end

endmodule

// File: rtl/core/ctc_queue.sv
// Small command queue that lets the front and back stall independently.
// Depends on ctc_pkg for the command type and queue depth.
module ctc_queue
  import ctc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  ctc_cmd_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output ctc_cmd_t pop_data
);

  ctc_cmd_t          slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = count_r != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slots_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + (QPTR_W + 1)'(1);
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/ctc_back.sv
// Execution side: timer state, tick handling, rejected starts and the start sequence.
// Depends on ctc_pkg; drives the serial divider in ctc_div.
module ctc_back
  import ctc_pkg::*;
#(
  parameter int COUNTER_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  ctc_cmd_t cmd_data,
  output div_req_t div_req,
  input  div_rsp_t div_rsp,
  output logic     out_valid,
  input  logic     out_ready,
  output ctc_out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_TOG,
    S_BASE_REQ,
    S_BASE_WAIT,
    S_SELECT,
    S_COMMIT
  } state_t;

  localparam logic [31:0] CMAX = 32'((64'd1 << COUNTER_BITS) - 64'd1);

  state_t                  state_r, state_nxt;
  logic [7:0]              port_value_r, port_value_nxt;
  logic [7:0]              toggle_mask_r, toggle_mask_nxt;
  logic [31:0]             toggles_left_r, toggles_left_nxt;
  logic [COUNTER_BITS-1:0] compare_value_r, compare_value_nxt;
  prescale_t               prescale_select_r, prescale_select_nxt;
  logic [9:0]              prescale_count_r, prescale_count_nxt;
  logic [COUNTER_BITS-1:0] timer_count_r, timer_count_nxt;
  logic                    timer_on_r, timer_on_nxt;
  logic                    out_valid_r, out_valid_nxt;
  ctc_out_t                out_data_r, out_data_nxt;

  logic [7:0]              new_mask_r, new_mask_nxt;
  logic [23:0]             new_freq_r, new_freq_nxt;
  logic [15:0]             new_dur_r, new_dur_nxt;
  logic [31:0]             prod_r, prod_nxt;
  logic [31:0]             new_toggles_r, new_toggles_nxt;
  logic [31:0]             base_r, base_nxt;
  prescale_t               sel_try_r, sel_try_nxt;
  logic [COUNTER_BITS-1:0] new_compare_r, new_compare_nxt;

  logic                    out_free;
  logic                    presc_tick;
  logic                    match;
  logic [39:0]             product;
  logic [63:0]             recip_prod;
  logic [31:0]             ocr;
  logic                    fits;

  assign out_free   = !out_valid_r || out_ready;
  assign cmd_ready  = (state_r == S_IDLE) && (cmd_data.kind == CMD_START || out_free);
  assign presc_tick = prescale_count_r >= prescale_top(prescale_select_r);
  assign product    = {16'd0, new_freq_r} * {24'd0, new_dur_r};
  assign recip_prod = {32'd0, prod_r} * {32'd0, MS_RECIP};
  assign ocr        = (base_r >> prescale_shift(sel_try_r)) - 32'd1;
  assign fits       = ocr <= CMAX;

  always_comb begin
    div_req.start    = (state_r == S_BASE_REQ);
    div_req.dividend = DIV_W'(CPU_HZ);
    div_req.divisor  = DIV_W'(new_freq_r);
  end

  always_comb begin
    state_nxt           = state_r;
    port_value_nxt      = port_value_r;
    toggle_mask_nxt     = toggle_mask_r;
    toggles_left_nxt    = toggles_left_r;
    compare_value_nxt   = compare_value_r;
    prescale_select_nxt = prescale_select_r;
    prescale_count_nxt  = prescale_count_r;
    timer_count_nxt     = timer_count_r;
    timer_on_nxt        = timer_on_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_data_nxt        = out_data_r;
    new_mask_nxt        = new_mask_r;
    new_freq_nxt        = new_freq_r;
    new_dur_nxt         = new_dur_r;
    prod_nxt            = prod_r;
    new_toggles_nxt     = new_toggles_r;
    base_nxt            = base_r;
    sel_try_nxt         = sel_try_r;
    new_compare_nxt     = new_compare_r;
    match               = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          unique case (cmd_data.kind)
            CMD_START: begin
              new_mask_nxt = cmd_data.pin_mask;
              new_freq_nxt = cmd_data.frequency_hz;
              new_dur_nxt  = cmd_data.duration_ms;
              state_nxt    = S_MUL;
            end
            CMD_BAD: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{port_bits: port_value_r, running: timer_on_r,
                                compare_event: 1'b0, bad_start: 1'b1};
            end
            default: begin
              if (timer_on_r) begin
                if (presc_tick) begin
                  prescale_count_nxt = '0;
                  if (timer_count_r == compare_value_r) begin
                    match           = 1'b1;
                    timer_count_nxt = '0;
                    if (toggles_left_r == '0) begin
                      timer_on_nxt        = 1'b0;
                      prescale_select_nxt = PS_STOP;
                    end else begin
                      port_value_nxt   = port_value_r ^ toggle_mask_r;
                      toggles_left_nxt = toggles_left_r - 32'd1;
                    end
                  end else begin
                    timer_count_nxt = timer_count_r + COUNTER_BITS'(1);
                  end
                end else begin
                  prescale_count_nxt = prescale_count_r + 10'd1;
                end
              end
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{port_bits: port_value_nxt, running: timer_on_nxt,
                                compare_event: match, bad_start: 1'b0};
            end
          endcase
        end
      end
      S_MUL: begin
        prod_nxt  = product[31:0];
        state_nxt = S_TOG;
      end
      S_TOG: begin
        new_toggles_nxt = 32'(recip_prod >> MS_RECIP_SHIFT);
        state_nxt       = S_BASE_REQ;
      end
      S_BASE_REQ: begin
        state_nxt = S_BASE_WAIT;
      end
      S_BASE_WAIT: begin
        if (div_rsp.done) begin
          base_nxt    = div_rsp.quotient;
          sel_try_nxt = PS_DIV1;
          state_nxt   = S_SELECT;
        end
      end
      S_SELECT: begin
        // Walk the prescalers from the smallest; the largest is taken even if it overflows.
        if (fits || sel_try_r == PS_DIV1024) begin
          new_compare_nxt = ocr[COUNTER_BITS-1:0];
          state_nxt       = S_COMMIT;
        end else begin
          sel_try_nxt = prescale_t'(sel_try_r + 3'd1);
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          toggle_mask_nxt     = new_mask_r;
          toggles_left_nxt    = new_toggles_r;
          compare_value_nxt   = new_compare_r;
          prescale_select_nxt = sel_try_r;
          prescale_count_nxt  = '0;
          timer_count_nxt     = '0;
          timer_on_nxt        = 1'b1;
          out_valid_nxt       = 1'b1;
          out_data_nxt        = '{port_bits: port_value_r, running: 1'b1,
                                  compare_event: 1'b0, bad_start: 1'b0};
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      port_value_r      <= '0;
      toggle_mask_r     <= '0;
      toggles_left_r    <= '0;
      compare_value_r   <= '0;
      prescale_select_r <= PS_STOP;
      prescale_count_r  <= '0;
      timer_count_r     <= '0;
      timer_on_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      out_data_r        <= '0;
    end else begin
      state_r           <= state_nxt;
      port_value_r      <= port_value_nxt;
      toggle_mask_r     <= toggle_mask_nxt;
      toggles_left_r    <= toggles_left_nxt;
      compare_value_r   <= compare_value_nxt;
      prescale_select_r <= prescale_select_nxt;
      prescale_count_r  <= prescale_count_nxt;
      timer_count_r     <= timer_count_nxt;
      timer_on_r        <= timer_on_nxt;
      out_valid_r       <= out_valid_nxt;
      out_data_r        <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_mask_r    <= new_mask_nxt;
    new_freq_r    <= new_freq_nxt;
    new_dur_r     <= new_dur_nxt;
    prod_r        <= prod_nxt;
    new_toggles_r <= new_toggles_nxt;
    base_r        <= base_nxt;
    sel_try_r     <= sel_try_nxt;
    new_compare_r <= new_compare_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/ctc_tone_generator_core.sv
// Square-wave tone generator on a CTC timer. Each tick item is one cpu clock
// and each start item loads a new tone. Ticks and rejected starts (zero
// frequency) are handled in the idle state of the execution stage, so a steady
// stream of ticks moves at one item per cycle while the output is not stalled,
// through the input stage, the four-entry command queue and the output register.
// A valid start runs in steps: the 24x16 multiply, the reciprocal multiply that
// turns the product into a toggle count, a division on the bit-serial divider
// for the base compare value, and a walk over the prescaler choices.
// Items behind a start wait in the queue and are taken in order once it ends.
module ctc_tone_generator_core
  import ctc_pkg::*;
#(
  parameter int COUNTER_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ctc_out_t out_data
);

  logic     f_valid;
  logic     f_ready;
  ctc_cmd_t f_cmd;
  logic     q_valid;
  logic     q_ready;
  ctc_cmd_t q_cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  ctc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_cmd)
  );

  ctc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  ctc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ctc_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_cmd),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // A division result is a single-cycle pulse.
  a_div_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |=> !div_rsp.done)
    else $error("divider done held for more than one cycle");

  // A division cannot finish in the cycle right after it was requested.
  a_div_not_instant: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> !div_rsp.done)
    else $error("divider finished immediately after a request");

  // A rejected start never reports a compare match.
  a_bad_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_start |-> !out_data.compare_event)
    else $error("result flags both a rejected start and a compare match");
`endif

endmodule
